// ----- design/crc16fgc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fgc_pkg
// shared types, codes and the byte-wide crc-16 update for the frame
// crc generate and check block
// ----------------------------------------------------------------------------
package crc16fgc_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam int          QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic REG_MODE           = 1'b0;
    localparam logic REG_EXPECTED_COUNT = 1'b1;

    // mode codes
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    // status codes on the final beat of a frame
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT    = 2'd1;
    localparam logic [1:0] ST_CRC_MISMATCH = 2'd2;

    localparam logic [7:0] EXPECTED_COUNT_RESET = 8'd35;
    localparam logic [7:0] MIN_COUNT            = 8'd3;

    // one classified item between front and back
    typedef struct packed {
        logic [7:0]  data;
        logic        is_crc;
        logic        last;
        logic [1:0]  status;
        logic        append;
        logic [15:0] crc;
    } qent_t;

    // eight bit steps, data lsb first, register shifts out bit 15
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i] ^ c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/crc16fgc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fgc_front
// tracks frame position, runs the crc per accepted byte and classifies
// each byte into one queue entry for the back end
// ----------------------------------------------------------------------------
module crc16fgc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          data_byte,
    input  wire logic                mode,
    input  wire logic [7:0]          expected_count,
    output crc16fgc_pkg::qent_t      entry
);
    import crc16fgc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  rx_low_reg, rx_low_next;
    logic        cbad_reg, cbad_next;

    logic        first;
    logic        short_frame;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic [7:0]  len;
    logic [7:0]  len_m2;
    logic        cbad;
    logic [8:0]  pos_p1;
    logic [1:0]  final_status;

    always_comb
    begin
        first       = (idx_reg == 8'd0);
        crc_base    = first ? 16'd0 : crc_reg;
        short_frame = first && ((data_byte < MIN_COUNT) ||
                                ((mode == MODE_CHECK) && (expected_count < MIN_COUNT)));
        if (first)
            len = (mode == MODE_CHECK) ? expected_count : data_byte;
        else
            len = len_reg;
        cbad    = first ? ((mode == MODE_CHECK) && (data_byte != expected_count))
                        : cbad_reg;
        len_m2  = len - 8'd2;
        pos_p1  = {1'b0, idx_reg} + 9'd1;
        crc_upd = crc16_byte(crc_base, data_byte);

        if (cbad)
            final_status = ST_BAD_COUNT;
        else if ((rx_low_reg != crc_base[7:0]) || (data_byte != crc_base[15:8]))
            final_status = ST_CRC_MISMATCH;
        else
            final_status = ST_OK;

        entry        = '0;
        entry.data   = data_byte;
        entry.crc    = crc_upd;
        crc_next     = crc_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        rx_low_next  = rx_low_reg;
        cbad_next    = cbad_reg;

        if (accept)
        begin
            if (first && !short_frame)
                len_next = len;
            priority if (short_frame)
            begin
                entry.last   = 1'b1;
                entry.status = ST_BAD_COUNT;
                idx_next     = 8'd0;
                crc_next     = 16'd0;
                cbad_next    = 1'b0;
            end
            else if (mode == MODE_GENERATE)
            begin
                if (pos_p1 >= {1'b0, len_m2})
                begin
                    // last covered byte: crc bytes follow in the back end
                    entry.append = 1'b1;
                    idx_next     = 8'd0;
                    crc_next     = 16'd0;
                    cbad_next    = 1'b0;
                end
                else
                begin
                    idx_next  = pos_p1[7:0];
                    crc_next  = crc_upd;
                    cbad_next = cbad;
                end
            end
            else if (idx_reg < len_m2)
            begin
                idx_next  = pos_p1[7:0];
                crc_next  = crc_upd;
                cbad_next = cbad;
            end
            else if (idx_reg == len_m2)
            begin
                entry.is_crc = 1'b1;
                rx_low_next  = data_byte;
                idx_next     = pos_p1[7:0];
                crc_next     = crc_base;
                cbad_next    = cbad;
            end
            else
            begin
                entry.is_crc = 1'b1;
                entry.last   = 1'b1;
                entry.status = final_status;
                idx_next     = 8'd0;
                crc_next     = 16'd0;
                cbad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 16'd0;
            idx_reg    <= 8'd0;
            len_reg    <= 8'd0;
            rx_low_reg <= 8'd0;
            cbad_reg   <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            rx_low_reg <= rx_low_next;
            cbad_reg   <= cbad_next;
        end
    end

`ifndef SYNTHESIS
    // inside a frame the latched length is always a legal one
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 8'd0) |-> (len_reg >= MIN_COUNT))
        else $error("front: mid-frame with short latched length");
`endif

endmodule
`default_nettype wire

// ----- design/crc16fgc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fgc_queue
// short queue of classified entries between front and back end
// ----------------------------------------------------------------------------
module crc16fgc_queue #(
    parameter int DEPTH = crc16fgc_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire crc16fgc_pkg::qent_t wr_entry,
    input  wire logic                rd_en,
    output crc16fgc_pkg::qent_t      rd_entry,
    output logic                     q_full,
    output logic                     q_empty
);
    import crc16fgc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    qent_t         mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        q_full   = (cnt_reg == CW'(DEPTH));
        q_empty  = (cnt_reg == '0);
        rd_entry = mem[rptr_reg];
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en)
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
        if (rd_en)
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CW'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue: fill count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("queue: read when empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue: write when full");
`endif

endmodule
`default_nettype wire

// ----- design/crc16fgc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fgc_back
// expands queue entries into result beats (echo, then crc low and high
// when appending) and holds them in the output register
// ----------------------------------------------------------------------------
module crc16fgc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crc16fgc_pkg::qent_t head,
    input  wire logic                q_empty,
    output logic                     deq,
    input  wire logic                pop,
    output logic                     empty,
    output logic [7:0]               out_byte,
    output logic                     is_crc,
    output logic                     frame_last,
    output logic [1:0]               status
);
    import crc16fgc_pkg::*;

    localparam logic [1:0] PH_DATA   = 2'd0;
    localparam logic [1:0] PH_CRC_LO = 2'd1;
    localparam logic [1:0] PH_CRC_HI = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       ocrc_reg, ocrc_next;
    logic       olast_reg, olast_next;
    logic [1:0] ost_reg, ost_next;
    logic       load;

    always_comb
    begin
        load        = !q_empty && (!ovalid_reg || pop);
        deq         = 1'b0;
        phase_next  = phase_reg;
        ovalid_next = ovalid_reg && !pop;
        obyte_next  = obyte_reg;
        ocrc_next   = ocrc_reg;
        olast_next  = olast_reg;
        ost_next    = ost_reg;

        if (load)
        begin
            ovalid_next = 1'b1;
            unique case (phase_reg)
                PH_DATA:
                begin
                    obyte_next = head.data;
                    ocrc_next  = head.is_crc;
                    olast_next = head.last;
                    ost_next   = head.status;
                    if (head.append)
                        phase_next = PH_CRC_LO;
                    else
                        deq = 1'b1;
                end
                PH_CRC_LO:
                begin
                    obyte_next = head.crc[7:0];
                    ocrc_next  = 1'b1;
                    olast_next = 1'b0;
                    ost_next   = ST_OK;
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    obyte_next = head.crc[15:8];
                    ocrc_next  = 1'b1;
                    olast_next = 1'b1;
                    ost_next   = ST_OK;
                    phase_next = PH_DATA;
                    deq        = 1'b1;
                end
                default:
                begin
                    phase_next  = PH_DATA;
                    ovalid_next = ovalid_reg && !pop;
                end
            endcase
        end

        empty      = !ovalid_reg;
        out_byte   = obyte_reg;
        is_crc     = ocrc_reg;
        frame_last = olast_reg;
        status     = ost_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DATA;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // result payload, only meaningful while the output register is valid
    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        ocrc_reg  <= ocrc_next;
        olast_reg <= olast_next;
        ost_reg   <= ost_next;
    end

`ifndef SYNTHESIS
    // mid-expansion the head entry must stay put and be an appending one
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DATA) |-> (!q_empty && head.append))
        else $error("back: crc expansion without an appending head");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) || (phase_reg == PH_CRC_LO) || (phase_reg == PH_CRC_HI))
        else $error("back: illegal phase");
`endif

endmodule
`default_nettype wire

// ----- design/crc16_frame_generate_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_generate_check
// count-prefixed frame crc-16 (poly 0x8005, init 0, lsb-first data)
// generator and checker
// ----------------------------------------------------------------------------
// Accepts one byte per clock while full is low; the crc update is a single
// byte-wide step in the front end, so input throughput is one byte each cycle.
// The back end drains results at one beat per cycle from its output register
// while pop is held high, so a byte that yields one result keeps pace, while a
// generate-mode frame-ending byte yields three beats (echo, crc low, crc high);
// a DEPTH-entry queue between the two absorbs that burst. When nothing waits
// ahead of it, an accepted byte is written into the queue and then loaded into
// the output register that drives the result ports. Configuration writes
// are always ready and are meant for idle periods; mode is sampled on every
// byte, expected_count at each count byte. No clearing pass after reset.
// ----------------------------------------------------------------------------
module crc16_frame_generate_check #(
    parameter int DEPTH = crc16fgc_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             is_crc,
    output logic             frame_last,
    output logic [1:0]       status
);
    import crc16fgc_pkg::*;

    logic       mode_reg;
    logic [7:0] exp_cnt_reg;
    logic       accept;
    logic       q_empty;
    logic       deq;
    qent_t      wr_entry;
    qent_t      head;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_GENERATE;
            exp_cnt_reg <= EXPECTED_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:           mode_reg    <= cfg_data[0];
                REG_EXPECTED_COUNT: exp_cnt_reg <= cfg_data;
                default:            mode_reg    <= mode_reg;
            endcase
        end
    end

    crc16fgc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .mode           (mode_reg),
        .expected_count (exp_cnt_reg),
        .entry          (wr_entry)
    );

    crc16fgc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_entry (wr_entry),
        .rd_en    (deq),
        .rd_entry (head),
        .q_full   (full),
        .q_empty  (q_empty)
    );

    crc16fgc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .is_crc     (is_crc),
        .frame_last (frame_last),
        .status     (status)
    );

endmodule
`default_nettype wire
